>>> rtl/core/text_console_writer_core_assert.svh
// Assertion macros shared by the text console writer RTL.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef TEXT_CONSOLE_WRITER_CORE_ASSERT_SVH
`define TEXT_CONSOLE_WRITER_CORE_ASSERT_SVH

`ifndef SYNTH
`define TCW_ASSERT_IMPLIES(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define TCW_ASSERT_NEVER(name, clk, rst, cond, msg) \
  name: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define TCW_ASSERT_IMPLIES(name, clk, rst, ante, cons, msg)
`define TCW_ASSERT_NEVER(name, clk, rst, cond, msg)
`endif

`endif

>>> rtl/core/tcw_pkg.sv
// Shared types and constants for the text console writer.
// No dependencies; used by every module in rtl/core.
`timescale 1ns / 1ps

package tcw_pkg;

  localparam int COLUMNS_DEF = 80;
  localparam int ROWS_DEF    = 25;
  localparam int CELL_W      = 16;

  localparam logic [7:0] NEWLINE_CODE     = 8'd10;
  localparam logic [7:0] SPACE_CODE       = 8'd32;
  localparam logic [7:0] TEXT_COLOR_RESET = 8'd7;

  typedef enum logic [1:0] {
    OP_PUT   = 2'd0,
    OP_CLEAR = 2'd1,
    OP_READ  = 2'd2
  } tcw_op_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_FILL,
    S_WRITE,
    S_READ,
    S_EMIT
  } tcw_state_t;

  typedef struct packed {
    logic [1:0] opcode;
    logic [7:0] char_code;
    logic [4:0] cell_row;
    logic [6:0] cell_column;
  } tcw_in_t;

  typedef struct packed {
    logic [10:0] cursor_position;
    logic [7:0]  read_character;
    logic [7:0]  read_attribute;
    logic        scrolled;
  } tcw_out_t;

endpackage

>>> rtl/core/text_console_writer_core.sv
// Text console writer: ROWS x COLUMNS character cells (attribute high byte,
// character low byte) held in one single-port-write cell memory. A put passes
// EXEC and WRITE, an in-range read EXEC and READ, a newline or an unused opcode
// EXEC alone; each then loads its result in EMIT once the output is free.
// A newline or wrap on the last row scrolls: the top row pointer rotates, so no
// cells move, and the new bottom row is blanked at one cell per cycle before
// any write. Clear blanks every cell. The memory's single write port paces both
// fills. One item is in work at a time; a new item is taken while the previous
// result waits in the output register.
// Depends on tcw_pkg, tcw_screen_ram and text_console_writer_core_assert.svh.
`timescale 1ns / 1ps
`include "text_console_writer_core_assert.svh"

module text_console_writer_core #(
  parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
  parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  tcw_pkg::tcw_in_t in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output tcw_pkg::tcw_out_t out_data,
  input  logic             cfg_we,
  input  logic [7:0]       cfg_data
);

  localparam int TOTAL = ROWS * COLUMNS;
  localparam int AW    = $clog2(TOTAL);
  localparam int RW    = $clog2(ROWS);
  localparam int CW    = $clog2(COLUMNS + 1);
  localparam int FW    = $clog2(TOTAL + 1);

  tcw_pkg::tcw_state_t state, state_next;
  tcw_pkg::tcw_in_t    item, item_next;

  logic [7:0]    text_color;
  logic [RW-1:0] cursor_row, cursor_row_next;
  logic [CW-1:0] cursor_column, cursor_column_next;
  logic [RW-1:0] top_row, top_row_next;
  logic [AW-1:0] top_base, top_base_next;
  logic [AW-1:0] cursor_base, cursor_base_next;
  logic [AW-1:0] fill_addr, fill_addr_next;
  logic [FW-1:0] fill_left, fill_left_next;
  logic          res_scrolled, res_scrolled_next;
  logic [7:0]    res_char, res_char_next;
  logic [7:0]    res_attr, res_attr_next;
  logic          out_valid_next;
  tcw_pkg::tcw_out_t out_data_next;

  logic                       ram_we, ram_re;
  logic [AW-1:0]              ram_waddr, ram_raddr;
  logic [tcw_pkg::CELL_W-1:0] ram_wdata, ram_rdata;

  logic          is_put, is_nl, need_line, at_bottom, rd_in_range, fill_done, out_free;
  logic [RW:0]   rd_sum;
  logic [RW-1:0] rd_phys;
  logic [FW-1:0] pos_full;

  assign is_put      = item.opcode == tcw_pkg::OP_PUT;
  assign is_nl       = item.char_code == tcw_pkg::NEWLINE_CODE;
  assign need_line   = is_nl || (cursor_column >= CW'(COLUMNS));
  assign at_bottom   = cursor_row == RW'(ROWS - 1);
  assign rd_in_range = (int'(item.cell_row) < ROWS) && (int'(item.cell_column) < COLUMNS);
  assign fill_done   = fill_left == FW'(1);
  assign out_free    = !out_valid || out_ready;
  assign in_ready    = state == tcw_pkg::S_IDLE;

  // physical row of a logical row: rotate by the top row pointer
  assign rd_sum  = (RW + 1)'(item.cell_row) + (RW + 1)'(top_row);
  assign rd_phys = (rd_sum >= (RW + 1)'(ROWS)) ? RW'(rd_sum - (RW + 1)'(ROWS)) : RW'(rd_sum);
  assign pos_full = FW'(cursor_row * COLUMNS) + FW'(cursor_column);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      tcw_pkg::S_IDLE: begin
        if (in_valid) state_next = tcw_pkg::S_EXEC;
      end
      tcw_pkg::S_EXEC: begin
        priority case (item.opcode)
          tcw_pkg::OP_PUT: begin
            if (need_line && at_bottom) state_next = tcw_pkg::S_FILL;
            else if (!is_nl)            state_next = tcw_pkg::S_WRITE;
            else                        state_next = tcw_pkg::S_EMIT;
          end
          tcw_pkg::OP_CLEAR: state_next = tcw_pkg::S_FILL;
          tcw_pkg::OP_READ:  state_next = rd_in_range ? tcw_pkg::S_READ : tcw_pkg::S_EMIT;
          default:           state_next = tcw_pkg::S_EMIT;
        endcase
      end
      tcw_pkg::S_FILL: begin
        if (fill_done) begin
          state_next = (is_put && !is_nl) ? tcw_pkg::S_WRITE : tcw_pkg::S_EMIT;
        end
      end
      tcw_pkg::S_WRITE: state_next = tcw_pkg::S_EMIT;
      tcw_pkg::S_READ:  state_next = tcw_pkg::S_EMIT;
      tcw_pkg::S_EMIT: begin
        if (out_free) state_next = tcw_pkg::S_IDLE;
      end
      default: state_next = tcw_pkg::S_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    item_next          = item;
    cursor_row_next    = cursor_row;
    cursor_column_next = cursor_column;
    top_row_next       = top_row;
    top_base_next      = top_base;
    cursor_base_next   = cursor_base;
    fill_addr_next     = fill_addr;
    fill_left_next     = fill_left;
    res_scrolled_next  = res_scrolled;
    res_char_next      = res_char;
    res_attr_next      = res_attr;
    out_data_next      = out_data;
    out_valid_next     = out_valid && !out_ready;
    ram_we             = 1'b0;
    ram_waddr          = fill_addr;
    ram_wdata          = {text_color, tcw_pkg::SPACE_CODE};
    ram_re             = 1'b0;
    ram_raddr          = AW'(rd_phys * COLUMNS) + AW'(item.cell_column);

    unique case (state)
      tcw_pkg::S_IDLE: begin
        if (in_valid) item_next = in_data;
      end
      tcw_pkg::S_EXEC: begin
        res_scrolled_next = 1'b0;
        res_char_next     = '0;
        res_attr_next     = '0;
        priority case (item.opcode)
          tcw_pkg::OP_PUT: begin
            if (need_line) begin
              cursor_column_next = '0;
              if (!at_bottom) begin
                cursor_row_next  = cursor_row + RW'(1);
                cursor_base_next = (cursor_base == AW'(TOTAL - COLUMNS)) ? '0
                                 : cursor_base + AW'(COLUMNS);
              end else begin
                // old top row becomes the new bottom row
                res_scrolled_next = 1'b1;
                fill_addr_next    = top_base;
                fill_left_next    = FW'(COLUMNS);
                cursor_base_next  = top_base;
                top_row_next      = (top_row == RW'(ROWS - 1)) ? '0 : top_row + RW'(1);
                top_base_next     = (top_base == AW'(TOTAL - COLUMNS)) ? '0
                                  : top_base + AW'(COLUMNS);
              end
            end
          end
          tcw_pkg::OP_CLEAR: begin
            fill_addr_next     = '0;
            fill_left_next     = FW'(TOTAL);
            top_row_next       = '0;
            top_base_next      = '0;
            cursor_base_next   = '0;
            cursor_row_next    = '0;
            cursor_column_next = '0;
          end
          tcw_pkg::OP_READ: begin
            ram_re = rd_in_range;
          end
          default: ;
        endcase
      end
      tcw_pkg::S_FILL: begin
        ram_we         = 1'b1;
        fill_addr_next = fill_addr + AW'(1);
        fill_left_next = fill_left - FW'(1);
      end
      tcw_pkg::S_WRITE: begin
        ram_we             = 1'b1;
        ram_waddr          = cursor_base + AW'(cursor_column);
        ram_wdata          = {text_color, item.char_code};
        cursor_column_next = cursor_column + CW'(1);
      end
      tcw_pkg::S_READ: begin
        res_char_next = ram_rdata[7:0];
        res_attr_next = ram_rdata[15:8];
      end
      tcw_pkg::S_EMIT: begin
        if (out_free) begin
          out_valid_next                 = 1'b1;
          out_data_next.cursor_position  = 11'(pos_full);
          out_data_next.read_character   = res_char;
          out_data_next.read_attribute   = res_attr;
          out_data_next.scrolled         = res_scrolled;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= tcw_pkg::S_IDLE;
      out_valid     <= 1'b0;
      text_color    <= tcw_pkg::TEXT_COLOR_RESET;
      cursor_row    <= '0;
      cursor_column <= '0;
      top_row       <= '0;
      top_base      <= '0;
      cursor_base   <= '0;
      fill_left     <= '0;
    end else begin
      state         <= state_next;
      out_valid     <= out_valid_next;
      cursor_row    <= cursor_row_next;
      cursor_column <= cursor_column_next;
      top_row       <= top_row_next;
      top_base      <= top_base_next;
      cursor_base   <= cursor_base_next;
      fill_left     <= fill_left_next;
      if (cfg_we) text_color <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    item         <= item_next;
    fill_addr    <= fill_addr_next;
    res_scrolled <= res_scrolled_next;
    res_char     <= res_char_next;
    res_attr     <= res_attr_next;
    out_data     <= out_data_next;
  end

  tcw_screen_ram #(
    .DEPTH (TOTAL),
    .AW    (AW)
  ) u_screen_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  `TCW_ASSERT_NEVER(a_col_bound, clk, rst, cursor_column > CW'(COLUMNS), "cursor column past end")
  `TCW_ASSERT_NEVER(a_row_bound, clk, rst, cursor_row > RW'(ROWS - 1), "cursor row past bottom")
  `TCW_ASSERT_IMPLIES(a_fill_live, clk, rst, state == tcw_pkg::S_FILL, fill_left != '0, "fill with no cells left")
  `TCW_ASSERT_NEVER(a_write_state, clk, rst, ram_we && (state == tcw_pkg::S_IDLE || state == tcw_pkg::S_EMIT || state == tcw_pkg::S_READ), "cell write outside fill or put")
  `TCW_ASSERT_IMPLIES(a_put_room, clk, rst, state == tcw_pkg::S_WRITE, cursor_column < CW'(COLUMNS), "put at column past end")

endmodule

>>> rtl/core/tcw_screen_ram.sv
// Screen cell store: one write port, one read port, registered read data.
// Depends on tcw_pkg for the cell width.
`timescale 1ns / 1ps

module tcw_screen_ram #(
  parameter int DEPTH = tcw_pkg::ROWS_DEF * tcw_pkg::COLUMNS_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                      clk,
  input  logic                      we,
  input  logic [AW-1:0]             waddr,
  input  logic [tcw_pkg::CELL_W-1:0] wdata,
  input  logic                      re,
  input  logic [AW-1:0]             raddr,
  output logic [tcw_pkg::CELL_W-1:0] rdata
);

  logic [tcw_pkg::CELL_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
